[design/u8san_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer package
// Token kinds, queue entry type and the byte rules that the front and the
// back of the sanitizer share.
// ----------------------------------------------------------------------------
package u8san_pkg;

	// Number of token slots in one queue entry: lead, two held bytes, new byte.
	localparam int NUM_TOK     = 4;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = 2;
	localparam int FIFO_CW     = 3;

	// Fixed output bytes.
	localparam logic [7:0] EURO_B0   = 8'd226;
	localparam logic [7:0] EURO_B1   = 8'd130;
	localparam logic [7:0] EURO_B2   = 8'd172;
	localparam logic [7:0] LINE_LF   = 8'd10;
	localparam logic [7:0] LINE_CR   = 8'd13;
	localparam logic [7:0] PFX_C2    = 8'd194;
	localparam logic [7:0] PFX_C3    = 8'd195;
	localparam logic [7:0] REENC_OFS = 8'd64;

	// What the back does with one byte.
	typedef enum logic [2:0] {
		TK_NONE  = 3'd0,
		TK_PASS  = 3'd1,
		TK_EURO  = 3'd2,
		TK_NEL   = 3'd3,
		TK_PFX   = 3'd4,
		TK_REENC = 3'd5
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] data;
	} tok_t;

	typedef tok_t [NUM_TOK-1:0] u8san_entry_t;

	// Byte rules for a byte that does not open a pending sequence.
	function automatic tok_kind_t classify(input logic [7:0] c);
		tok_kind_t k;
		k = TK_NONE;
		if (c inside {[8'd32:8'd126]}) begin
			k = TK_PASS;
		end else if (c == 8'd128) begin
			k = TK_EURO;
		end else if (c == 8'd133) begin
			k = TK_NEL;
		end else if (c inside {[8'd160:8'd191]}) begin
			k = TK_PFX;
		end else if (c >= 8'd192) begin
			k = TK_REENC;
		end
		return k;
	endfunction

	// A lead byte of a well-formed multi-byte sequence.
	function automatic logic is_lead(input logic [7:0] c);
		return (c inside {[8'd194:8'd244]});
	endfunction

	function automatic logic is_cont(input logic [7:0] c);
		return (c inside {[8'd128:8'd191]});
	endfunction

	// Continuation bytes that a lead byte asks for.
	function automatic logic [1:0] need_of(input logic [7:0] c);
		logic [1:0] n;
		if (c < 8'd224) begin
			n = 2'd1;
		end else if (c < 8'd240) begin
			n = 2'd2;
		end else begin
			n = 2'd3;
		end
		return n;
	endfunction

	// Index of the final output byte of a token.
	function automatic logic [1:0] tok_end(input tok_kind_t k);
		logic [1:0] e;
		case (k)
			TK_EURO:  e = 2'd2;
			TK_NEL:   e = 2'd1;
			TK_PFX:   e = 2'd1;
			TK_REENC: e = 2'd1;
			default:  e = 2'd0;
		endcase
		return e;
	endfunction

	// Output byte number sub of a token.
	function automatic logic [7:0] tok_byte(input tok_t t, input logic [1:0] sub);
		logic [7:0] b;
		case (t.kind)
			TK_EURO:  b = (sub == 2'd0) ? EURO_B0 : ((sub == 2'd1) ? EURO_B1 : EURO_B2);
			TK_NEL:   b = (sub == 2'd0) ? LINE_LF : LINE_CR;
			TK_PFX:   b = (sub == 2'd0) ? PFX_C2 : t.data;
			TK_REENC: b = (sub == 2'd0) ? PFX_C3 : (t.data - REENC_OFS);
			default:  b = t.data;
		endcase
		return b;
	endfunction

endpackage

[design/utf8_stream_sanitizer.sv]
// The first output byte of an item passes the token queue and the back's token
// register before it reaches the single output byte register. Throughput: one
// output byte per cycle while the consumer pops; an item yields 0 to 10 bytes.
// Input items are taken every cycle while the four-entry token queue has room.
// Reset (arst_n low) clears the pending sequence, the queue and the output register.
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer
// Drops control bytes, maps stray high codes, re-encodes broken sequences and
// passes well-formed UTF-8 through, one input byte per item.
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_last
);
	import u8san_pkg::*;

	u8san_entry_t front_entry;
	u8san_entry_t fifo_dout;
	logic         front_has_work;
	logic         accept;
	logic         fifo_push;
	logic         fifo_full;
	logic         fifo_empty;
	logic         fifo_pop;
	logic         back_busy;

	assign full      = fifo_full;
	assign accept    = push && !fifo_full;
	assign fifo_push = accept && front_has_work;

	// Front: sequence tracking and classification.
	u8san_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.entry    (front_entry),
		.has_work (front_has_work)
	);

	// Queue between front and back.
	u8san_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.din    (front_entry),
		.full   (fifo_full),
		.pop    (fifo_pop),
		.dout   (fifo_dout),
		.empty  (fifo_empty)
	);

	// Back: token expansion and output register.
	u8san_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.fifo_dout  (fifo_dout),
		.fifo_pop   (fifo_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.busy       (back_busy)
	);

	// A queued entry is visible to the back in the next cycle.
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |=> !fifo_empty)
		else $error("queued entry not visible to the back");

	// With nothing queued or in progress, no output item can appear.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_empty && !back_busy && empty && !fifo_push) |=> empty)
		else $error("output item appeared with no work pending");

	// The queue only fills through a push from the front.
	a_full_by_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(fifo_push))
		else $error("queue became full without a push");

endmodule

[design/u8san_fifo.sv]
// ----------------------------------------------------------------------------
// Sanitizer token queue
// Short register queue of token entries between the front and the back.
// ----------------------------------------------------------------------------
module u8san_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  u8san_pkg::u8san_entry_t din,
	output logic                   full,
	input  logic                   pop,
	output u8san_pkg::u8san_entry_t dout,
	output logic                   empty
);
	import u8san_pkg::*;

	u8san_entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]       wr_ptr_q;
	logic [FIFO_AW-1:0]       rd_ptr_q;
	logic [FIFO_CW-1:0]       count_q;
	logic                     do_push;
	logic                     do_pop;

	assign full    = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

[design/u8san_front.sv]
// ----------------------------------------------------------------------------
// Sanitizer front
// Tracks the pending multi-byte sequence and turns each item into a queue
// entry of up to four classified tokens.
// ----------------------------------------------------------------------------
module u8san_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [7:0]              in_byte,
	input  logic                    in_last,
	output u8san_pkg::u8san_entry_t entry,
	output logic                    has_work
);
	import u8san_pkg::*;

	logic [7:0] lead_q;
	logic [1:0] need_q;
	logic [1:0] cnt_q;
	logic [7:0] cont_q [2];

	logic [7:0] lead_d;
	logic [1:0] need_d;
	logic [1:0] cnt_d;
	logic       wr_cont;
	logic [2:0] cnt_inc;
	logic [7:0] c0_now;

	assign cnt_inc = {1'b0, cnt_q} + 3'd1;
	assign c0_now  = (cnt_q == 2'd0) ? in_byte : cont_q[0];

	// Classification and next sequence state.
	always_comb begin
		for (int i = 0; i < NUM_TOK; i++) begin
			entry[i].kind = TK_NONE;
			entry[i].data = '0;
		end
		lead_d  = lead_q;
		need_d  = need_q;
		cnt_d   = cnt_q;
		wr_cont = 1'b0;

		if (need_q == 2'd0) begin
			// No sequence pending: a lead opens one unless the string ends.
			if (is_lead(in_byte) && !in_last) begin
				lead_d = in_byte;
				need_d = need_of(in_byte);
				cnt_d  = 2'd0;
			end else begin
				entry[3].kind = classify(in_byte);
				entry[3].data = in_byte;
			end
		end else if (is_cont(in_byte)) begin
			if (cnt_inc >= {1'b0, need_q}) begin
				// Sequence complete; the 194 pair that encodes a control code is dropped.
				if (!(need_q == 2'd1 && lead_q == PFX_C2 && in_byte < 8'd160)) begin
					entry[0].kind = TK_PASS;
					entry[0].data = lead_q;
					entry[1].kind = (cnt_q >= 2'd1) ? TK_PASS : TK_NONE;
					entry[1].data = cont_q[0];
					entry[2].kind = (cnt_q >= 2'd2) ? TK_PASS : TK_NONE;
					entry[2].data = cont_q[1];
					entry[3].kind = TK_PASS;
					entry[3].data = in_byte;
				end
				need_d = 2'd0;
				cnt_d  = 2'd0;
			end else begin
				// Hold the byte; a cut-off sequence is repaired at once.
				wr_cont = 1'b1;
				cnt_d   = cnt_inc[1:0];
				if (in_last) begin
					entry[0].kind = TK_REENC;
					entry[0].data = lead_q;
					entry[1].kind = classify(c0_now);
					entry[1].data = c0_now;
					if (cnt_q == 2'd1) begin
						entry[2].kind = classify(in_byte);
						entry[2].data = in_byte;
					end
					need_d = 2'd0;
					cnt_d  = 2'd0;
				end
			end
		end else begin
			// Broken sequence: re-encode the lead, replay held bytes.
			entry[0].kind = TK_REENC;
			entry[0].data = lead_q;
			entry[1].kind = (cnt_q >= 2'd1) ? classify(cont_q[0]) : TK_NONE;
			entry[1].data = cont_q[0];
			entry[2].kind = (cnt_q >= 2'd2) ? classify(cont_q[1]) : TK_NONE;
			entry[2].data = cont_q[1];
			need_d = 2'd0;
			cnt_d  = 2'd0;
			if (is_lead(in_byte) && !in_last) begin
				lead_d = in_byte;
				need_d = need_of(in_byte);
			end else begin
				entry[3].kind = classify(in_byte);
				entry[3].data = in_byte;
			end
		end
	end

	always_comb begin
		has_work = 1'b0;
		for (int i = 0; i < NUM_TOK; i++) begin
			has_work = has_work | (entry[i].kind != TK_NONE);
		end
	end

	// Sequence control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			need_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			lead_q <= lead_d;
			need_q <= need_d;
			cnt_q  <= cnt_d;
		end
	end

	// Held continuation bytes.
	always_ff @(posedge clk) begin
		if (accept && wr_cont) begin
			cont_q[cnt_q[0]] <= in_byte;
		end
	end

endmodule

[design/u8san_back.sv]
// ----------------------------------------------------------------------------
// Sanitizer back
// Expands queued tokens into output bytes, one per cycle unless an unpopped byte
// stalls it, into an output register that the consumer pops.
// ----------------------------------------------------------------------------
module u8san_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fifo_empty,
	input  u8san_pkg::u8san_entry_t fifo_dout,
	output logic                    fifo_pop,
	input  logic                    pop,
	output logic                    empty,
	output logic [7:0]              out_byte,
	output logic                    run_last,
	output logic                    busy
);
	import u8san_pkg::*;

	u8san_entry_t       toks_q;
	logic [NUM_TOK-1:0] mask_q;
	logic [1:0]         sub_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic [1:0]         cur_idx;
	logic [NUM_TOK-1:0] cur_oh;
	logic [NUM_TOK-1:0] rest;
	tok_t               cur_tok;
	logic               emit;
	logic               at_end;
	logic               load;
	logic [NUM_TOK-1:0] load_mask;

	// Lowest pending token is the one being expanded.
	always_comb begin
		cur_idx = '0;
		for (int i = NUM_TOK - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				cur_idx = 2'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_TOK; i++) begin
			load_mask[i] = (fifo_dout[i].kind != TK_NONE);
		end
	end

	assign cur_oh   = mask_q & (~mask_q + 1'b1);
	assign rest     = mask_q & ~cur_oh;
	assign cur_tok  = toks_q[cur_idx];
	assign busy     = (mask_q != '0);
	assign emit     = busy && (!out_valid_q || pop);
	assign at_end   = (sub_q == tok_end(cur_tok.kind));
	assign load     = !fifo_empty && (!busy || (emit && at_end && rest == '0));
	assign fifo_pop = load;

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign run_last = out_last_q;

	// Token sequencing and output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= load_mask;
				sub_q  <= '0;
			end else if (emit) begin
				if (at_end) begin
					mask_q <= rest;
					sub_q  <= '0;
				end else begin
					sub_q <= sub_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load) begin
			toks_q <= fifo_dout;
		end
		if (emit) begin
			out_byte_q <= tok_byte(cur_tok, sub_q);
			out_last_q <= at_end && (rest == '0);
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer testbench
// Feeds raw text bytes through the push/full side and drains the cleaned
// bytes through the empty/pop side. A behavioral copy of the sanitizer
// predicts every output byte and its run_last flag, and each popped item is
// compared with the oldest prediction. Directed bytes and sequences come
// first, then random text made mostly of well-formed characters.
// ----------------------------------------------------------------------------
module tb_top;
	import u8san_pkg::*;

	// Timeout limit; this leaves ample room over the worst case.
	localparam int CYCLE_LIMIT   = 500000;
	localparam int DRAIN_CYCLES  = 30;
	localparam int MAX_OUT       = 10;
	localparam int RANDOM_ITEMS  = 430;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
	} out_item_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       push     = 1'b0;
	logic [7:0] in_byte  = 8'd0;
	logic       in_last  = 1'b0;
	logic       pop      = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] out_byte;
	logic       run_last;

	// Predictor state: the pending multi-byte sequence.
	logic [7:0] seq_lead    = 8'd0;
	logic [1:0] seq_need    = 2'd0;
	logic [1:0] seq_have    = 2'd0;
	logic [7:0] seq_cont[2] = '{8'd0, 8'd0};

	logic [7:0] step_bytes[$];
	out_item_t  sanitized_q[$];

	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	int stall_left = 0;
	int mismatch_count = 0;
	int useful_items = 0;
	int cycle_count = 0;

	utf8_stream_sanitizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.run_last (run_last)
	);

	always #5 clk = ~clk;

	// Cycle budget for the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d items still expected", $time, sanitized_q.size());
			$display("tb_top failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void emit_byte(input logic [7:0] b);
		if (step_bytes.size() < MAX_OUT) begin
			step_bytes.push_back(b);
		end
	endfunction

	// Byte rules for a byte that is not part of a pending sequence.
	function automatic void apply_byte_rules(input logic [7:0] c, input logic l);
		if (c < 32) begin
			return;
		end else if (c < 127) begin
			emit_byte(c);
		end else if (c < 160) begin
			if (c == EURO_B1 - 8'd2) begin
				emit_byte(EURO_B0);
				emit_byte(EURO_B1);
				emit_byte(EURO_B2);
			end else if (c == 8'd133) begin
				emit_byte(LINE_LF);
				emit_byte(LINE_CR);
			end
		end else if (c < 192) begin
			emit_byte(PFX_C2);
			emit_byte(c);
		end else if (c < PFX_C2 || c >= 245 || l) begin
			emit_byte(PFX_C3);
			emit_byte(c - REENC_OFS);
		end else begin
			seq_lead = c;
			seq_need = (c < 224) ? 2'd1 : ((c < 240) ? 2'd2 : 2'd3);
			seq_have = 2'd0;
		end
	endfunction

	// Re-encode the lead of a failed sequence and replay its held bytes.
	function automatic void repair_sequence();
		int k;
		int cnt;
		cnt = (seq_have > 2) ? 2 : int'(seq_have);
		emit_byte(PFX_C3);
		emit_byte(seq_lead - REENC_OFS);
		seq_need = 2'd0;
		seq_have = 2'd0;
		for (k = 0; k < cnt; k++) begin
			apply_byte_rules(seq_cont[k], 1'b0);
		end
	endfunction

	// Work out the output bytes of one accepted input byte and queue them.
	function automatic void predict_sanitized(input logic [7:0] b, input logic l);
		int k;
		step_bytes.delete();
		if (seq_need == 2'd0) begin
			apply_byte_rules(b, l);
		end else if (b >= 128 && b < 192) begin
			if (int'(seq_have) + 1 >= int'(seq_need)) begin
				// A 194 lead with a byte below 160 encodes a control code: drop both.
				if (!(seq_need == 2'd1 && seq_lead == PFX_C2 && b < 160)) begin
					emit_byte(seq_lead);
					for (k = 0; k < int'(seq_have) && k < 2; k++) begin
						emit_byte(seq_cont[k]);
					end
					emit_byte(b);
				end
				seq_need = 2'd0;
				seq_have = 2'd0;
			end else begin
				seq_cont[seq_have[0]] = b;
				seq_have = seq_have + 2'd1;
				if (l) begin
					repair_sequence();
				end
			end
		end else begin
			repair_sequence();
			apply_byte_rules(b, l);
		end
		for (k = 0; k < step_bytes.size(); k++) begin
			sanitized_q.push_back('{b: step_bytes[k], l: (k == step_bytes.size() - 1)});
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stalls and checking of each popped item
	// ------------------------------------------------------------------

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (sanitized_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, got out_byte %0d run_last %0d",
						$time, out_byte, run_last);
					mismatch_count++;
				end else begin
					want = sanitized_q.pop_front();
					if (out_byte !== want.b) begin
						$display("%0t: out_byte mismatch, expected %0d, got %0d",
							$time, want.b, out_byte);
						mismatch_count++;
					end
					if (run_last !== want.l) begin
						$display("%0t: run_last mismatch, expected %0d, got %0d",
							$time, want.l, run_last);
						mismatch_count++;
					end
				end
				stall_left = rx_idle ? $urandom_range(0, 12) : 0;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			pop <= (stall_left == 0);
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Send one byte; push stays high when the next item follows at once.
	task automatic send_item(input logic [7:0] b, input logic l);
		int gap;
		logic was_pending;
		gap = tx_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		in_last <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		was_pending = (seq_need != 2'd0);
		predict_sanitized(b, l);
		if (step_bytes.size() > 0 || was_pending || seq_need != 2'd0) begin
			useful_items++;
		end
	endtask

	// Hold off the sender until every predicted item has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		while (sanitized_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Single bytes across every class, without idling.
	task automatic test_byte_rules();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_item(8'd0, 1'b0);
		send_item(8'd127, 1'b0);
		send_item(8'd126, 1'b0);
		send_item(8'd128, 1'b0);
		send_item(8'd133, 1'b0);
		send_item(8'd159, 1'b0);
		send_item(8'd160, 1'b0);
		send_item(8'd193, 1'b0);
		send_item(8'd255, 1'b1);
	endtask

	// Complete, dropped, broken and cut-off sequences.
	task automatic test_sequences();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		// A 194 pair that encodes a control code is dropped.
		send_item(8'd194, 1'b0);
		send_item(8'd159, 1'b0);
		// Well-formed three-byte and four-byte characters.
		send_item(8'd226, 1'b0);
		send_item(8'd130, 1'b0);
		send_item(8'd172, 1'b0);
		send_item(8'd240, 1'b0);
		send_item(8'd144, 1'b0);
		send_item(8'd128, 1'b0);
		send_item(8'd191, 1'b1);
		// Lead byte at the end of the string.
		send_item(8'd244, 1'b1);
		// Broken with nothing held, then broken with two held bytes (ten results).
		send_item(8'd223, 1'b0);
		send_item(8'd65, 1'b0);
		send_item(8'd240, 1'b0);
		send_item(8'd128, 1'b0);
		send_item(8'd128, 1'b0);
		send_item(8'd255, 1'b0);
		// Sequence cut off by the end of the string.
		send_item(8'd226, 1'b0);
		send_item(8'd160, 1'b1);
		wait_drained();
	endtask

	// One random character: mostly well-formed, some broken, some noise.
	task automatic send_random_char();
		int kind;
		int len;
		int need;
		int held;
		int k;
		logic [7:0] lead;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			len = $urandom_range(1, 4);
			case (len)
				1: lead = 8'($urandom_range(32, 126));
				2: lead = 8'($urandom_range(194, 223));
				3: lead = 8'($urandom_range(224, 239));
				default: lead = 8'($urandom_range(240, 244));
			endcase
			send_item(lead, len == 1 && $urandom_range(0, 7) == 0);
			for (k = 1; k < len; k++) begin
				send_item(8'($urandom_range(128, 191)),
					k == len - 1 && $urandom_range(0, 7) == 0);
			end
		end else if (kind < 75) begin
			lead = 8'($urandom_range(194, 244));
			need = (lead < 224) ? 1 : ((lead < 240) ? 2 : 3);
			held = $urandom_range(0, need - 1);
			send_item(lead, 1'b0);
			for (k = 0; k < held; k++) begin
				// The last held byte may end the string and cut the sequence off.
				send_item(8'($urandom_range(128, 191)),
					k == held - 1 && $urandom_range(0, 1) == 0);
			end
			if ($urandom_range(0, 1) == 0) begin
				send_item(8'($urandom_range(0, 127)), $urandom_range(0, 3) == 0);
			end else begin
				send_item(8'($urandom_range(192, 255)), $urandom_range(0, 3) == 0);
			end
		end else begin
			send_item(8'($urandom), $urandom_range(0, 3) == 0);
		end
	endtask

	// Random text with changing idle patterns and one full drain midway.
	task automatic test_random_text();
		int goal;
		bit drained;
		goal = useful_items + RANDOM_ITEMS;
		drained = 1'b0;
		while (useful_items < goal) begin
			if ($urandom_range(0, 39) == 0) begin
				tx_idle = ($urandom_range(0, 3) != 0);
				rx_idle = ($urandom_range(0, 3) != 0);
			end
			if (!drained && useful_items > goal - RANDOM_ITEMS / 2) begin
				wait_drained();
				drained = 1'b1;
			end
			send_random_char();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_byte_rules();
		test_sequences();
		test_random_text();
		rx_idle = 1'b0;
		wait_drained();
		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

[sim.f]
design/u8san_pkg.sv
design/u8san_fifo.sv
design/u8san_front.sv
design/u8san_back.sv
design/utf8_stream_sanitizer.sv
tb/tb_top.sv
